// ----- design/hesd_pkg.sv -----
// ----------------------------------------------------------------------------
// hesd_pkg
// Shared types, codes and helpers for the hex escape string decoder.
// ----------------------------------------------------------------------------
package hesd_pkg;

  // Default width of the decoded byte counter.
  localparam int LENGTH_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CAP_W       = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  // Register index codes (taken from the word address).
  localparam logic REG_CAPACITY = 1'b0;

  // Result queue geometry.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // Field widths of a result word.
  localparam int LEN_OUT_W = 16;

  // Characters of interest.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_X      = 8'h78;  // 'x'
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'
  localparam logic [7:0] CH_LA     = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF     = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF     = 8'h46;  // 'F'
  localparam logic [3:0] HEX_TEN   = 4'd10;

  // Status codes carried by the final word.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LONG = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_BSLASH = 2'd1,
    PH_HIGH   = 2'd2,
    PH_LOW    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]           data;
    logic                 is_final;
    logic [1:0]           status;
    logic [LEN_OUT_W-1:0] length;
    logic                 last;
  } result_t;

  // Up to two result words produced by one input word.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b inside {[CH_0:CH_9]}) begin
      h.valid = 1'b1;
      h.value = 4'(b - CH_0);
    end else if (b inside {[CH_LA:CH_LF]}) begin
      h.valid = 1'b1;
      h.value = HEX_TEN + 4'(b - CH_LA);
    end else if (b inside {[CH_UA:CH_UF]}) begin
      h.valid = 1'b1;
      h.value = HEX_TEN + 4'(b - CH_UA);
    end
    return h;
  endfunction

  function automatic result_t mk_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.data = b;
    return r;
  endfunction

  function automatic result_t mk_final(input logic [1:0] st,
                                       input logic [LEN_OUT_W-1:0] len);
    result_t r;
    r = '0;
    r.is_final = 1'b1;
    r.status   = st;
    r.length   = len;
    return r;
  endfunction

endpackage

// ----- design/hesd_regs.sv -----
// ----------------------------------------------------------------------------
// hesd_regs
// APB-style register file holding the capacity register.
// ----------------------------------------------------------------------------
module hesd_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hesd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hesd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hesd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [hesd_pkg::CAP_W-1:0]        capacity
);

  logic [hesd_pkg::CAP_W-1:0] capacity_r;
  logic [hesd_pkg::CAP_W-1:0] capacity_nxt;
  logic                       reg_idx;
  logic                       wr_en;

  // word index; byte offset bits are ignored
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_en && (reg_idx == hesd_pkg::REG_CAPACITY)) begin
      capacity_nxt = pwdata[hesd_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= hesd_pkg::CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == hesd_pkg::REG_CAPACITY) begin
      prdata = hesd_pkg::CFG_DATA_W'(capacity_r);
    end
  end

  assign capacity = capacity_r;

endmodule

// ----- design/hesd_core.sv -----
// ----------------------------------------------------------------------------
// hesd_core
// Escape decode state machine: one input word in, up to two result words out.
// ----------------------------------------------------------------------------
module hesd_core #(
  parameter int LENGTH_BITS = hesd_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [7:0]                  in_byte,
  input  logic [hesd_pkg::CAP_W-1:0]  capacity,
  output hesd_pkg::push_t             push
);

  // compare width covers both the counter and the capacity register
  localparam int CW = (LENGTH_BITS > hesd_pkg::CAP_W) ? LENGTH_BITS : hesd_pkg::CAP_W;

  hesd_pkg::phase_t        phase_r, phase_nxt;
  logic [3:0]              nib_r, nib_nxt;
  logic [LENGTH_BITS-1:0]  cnt_r, cnt_nxt;
  logic [1:0]              err_r, err_nxt;

  logic [LENGTH_BITS-1:0]  cnt_inc, cnt_inc2;
  logic [CW-1:0]           cap_w, mask_w, cap_eff, cnt_w, cnt_inc_w;
  logic                    at_cap, at_cap1;
  logic                    is_nul, is_bs, is_x;
  hesd_pkg::hex_t          hv;
  hesd_pkg::result_t       r0, r1;
  logic [1:0]              n;

  assign is_nul = (in_byte == hesd_pkg::CH_NUL);
  assign is_bs  = (in_byte == hesd_pkg::CH_BSLASH);
  assign is_x   = (in_byte == hesd_pkg::CH_X);
  assign hv     = hesd_pkg::hex_digit(in_byte);

  assign cnt_inc  = cnt_r + LENGTH_BITS'(1);
  assign cnt_inc2 = cnt_r + LENGTH_BITS'(2);

  // a narrow counter saturates the effective capacity at its largest value
  assign cap_w     = CW'(capacity);
  assign mask_w    = CW'({LENGTH_BITS{1'b1}});
  assign cap_eff   = (cap_w > mask_w) ? mask_w : cap_w;
  assign cnt_w     = CW'(cnt_r);
  assign cnt_inc_w = CW'(cnt_inc);
  assign at_cap    = (cnt_w >= cap_eff);
  assign at_cap1   = (cnt_inc_w >= cap_eff);  // check after a flushed backslash

  // next state
  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    if (acc) begin
      if (err_r != hesd_pkg::ST_OK) begin
        // discarding until NUL
      end else begin
        case (phase_r)
          hesd_pkg::PH_NORMAL: begin
            if (!is_nul) begin
              if (at_cap) begin
                err_nxt = hesd_pkg::ST_LONG;
              end else if (is_bs) begin
                phase_nxt = hesd_pkg::PH_BSLASH;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
          end
          hesd_pkg::PH_BSLASH: begin
            if (is_x) begin
              phase_nxt = hesd_pkg::PH_HIGH;
            end else begin
              phase_nxt = hesd_pkg::PH_NORMAL;
              cnt_nxt   = cnt_inc;
              if (!is_nul) begin
                if (at_cap1) begin
                  err_nxt = hesd_pkg::ST_LONG;
                end else if (is_bs) begin
                  phase_nxt = hesd_pkg::PH_BSLASH;
                end else begin
                  cnt_nxt = cnt_inc2;
                end
              end
            end
          end
          hesd_pkg::PH_HIGH: begin
            if (!hv.valid) begin
              err_nxt   = hesd_pkg::ST_BAD;
              phase_nxt = hesd_pkg::PH_NORMAL;
            end else begin
              nib_nxt   = hv.value;
              phase_nxt = hesd_pkg::PH_LOW;
            end
          end
          hesd_pkg::PH_LOW: begin
            phase_nxt = hesd_pkg::PH_NORMAL;
            if (!hv.valid) begin
              err_nxt = hesd_pkg::ST_BAD;
            end else begin
              nib_nxt = '0;
              cnt_nxt = cnt_inc;
            end
          end
          default: begin
            phase_nxt = hesd_pkg::PH_NORMAL;
          end
        endcase
      end
      // the terminator always ends the string and restarts
      if (is_nul) begin
        phase_nxt = hesd_pkg::PH_NORMAL;
        nib_nxt   = '0;
        cnt_nxt   = '0;
        err_nxt   = hesd_pkg::ST_OK;
      end
    end
  end

  // outputs
  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (acc) begin
      if (err_r != hesd_pkg::ST_OK) begin
        if (is_nul) begin
          r0 = hesd_pkg::mk_final(err_r, cnt_w[hesd_pkg::LEN_OUT_W-1:0]);
          n  = 2'd1;
        end
      end else begin
        case (phase_r)
          hesd_pkg::PH_NORMAL: begin
            if (is_nul) begin
              r0 = hesd_pkg::mk_final(hesd_pkg::ST_OK, cnt_w[hesd_pkg::LEN_OUT_W-1:0]);
              n  = 2'd1;
            end else if (!at_cap && !is_bs) begin
              r0 = hesd_pkg::mk_byte(in_byte);
              n  = 2'd1;
            end
          end
          hesd_pkg::PH_BSLASH: begin
            if (!is_x) begin
              r0 = hesd_pkg::mk_byte(hesd_pkg::CH_BSLASH);
              n  = 2'd1;
              if (is_nul) begin
                r1 = hesd_pkg::mk_final(hesd_pkg::ST_OK,
                                        cnt_inc_w[hesd_pkg::LEN_OUT_W-1:0]);
                n  = 2'd2;
              end else if (!at_cap1 && !is_bs) begin
                r1 = hesd_pkg::mk_byte(in_byte);
                n  = 2'd2;
              end
            end
          end
          hesd_pkg::PH_HIGH: begin
            if (!hv.valid && is_nul) begin
              r0 = hesd_pkg::mk_final(hesd_pkg::ST_BAD, cnt_w[hesd_pkg::LEN_OUT_W-1:0]);
              n  = 2'd1;
            end
          end
          hesd_pkg::PH_LOW: begin
            if (!hv.valid) begin
              if (is_nul) begin
                r0 = hesd_pkg::mk_final(hesd_pkg::ST_BAD, cnt_w[hesd_pkg::LEN_OUT_W-1:0]);
                n  = 2'd1;
              end
            end else begin
              r0 = hesd_pkg::mk_byte({nib_r, hv.value});
              n  = 2'd1;
            end
          end
          default: begin
            n = 2'd0;
          end
        endcase
      end
      if (n == 2'd1) begin
        r0.last = 1'b1;
      end
      if (n == 2'd2) begin
        r1.last = 1'b1;
      end
    end
  end

  assign push.count  = n;
  assign push.first  = r0;
  assign push.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hesd_pkg::PH_NORMAL;
      nib_r   <= '0;
      cnt_r   <= '0;
      err_r   <= hesd_pkg::ST_OK;
    end else begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- design/hesd_rqueue.sv -----
// ----------------------------------------------------------------------------
// hesd_rqueue
// Result word queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module hesd_rqueue (
  input  logic              clk,
  input  logic              rst_n,
  input  hesd_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output hesd_pkg::result_t head
);

  localparam int PW = hesd_pkg::RQ_PTR_W;
  localparam int CNW = hesd_pkg::RQ_CNT_W;

  hesd_pkg::result_t mem_r [hesd_pkg::RQ_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0]    cnt_r, cnt_nxt;
  logic              pop;

  assign pop        = out_valid & ~out_stall;
  assign wr_ptr_nxt = wr_ptr_r + PW'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign cnt_nxt    = cnt_r + CNW'(push.count) - CNW'(pop);

  // room for two words, judged on registered fill only
  assign room      = (cnt_r <= CNW'(hesd_pkg::RQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.second;
    end
  end

endmodule

// ----- design/hex_escape_string_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// hex_escape_string_decoder_unit
// Streaming decoder for backslash-x hex escapes in NUL-terminated strings.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle whenever the result queue has room for
// two words. The decode state machine turns each byte into zero, one or two
// result words in the same cycle and writes them into a four-entry queue;
// the output side drains one word per cycle while out_stall is low. A byte
// that yields at most one word therefore flows at one byte per clock, while a
// byte that flushes a held backslash together with a second word takes an
// extra output slot to drain; the single read port of the result queue sets
// that limit. Result words are registered in the queue. Each result
// word is either a decoded byte (out_is_final low) or the end-of-string word
// (out_is_final high) carrying the status (ok, too long, invalid escape) and
// the decoded length; out_last marks the last word caused by one input byte.
// The capacity register (byte address 0, reset 65535) is written through the
// APB-style port and takes effect at the next capacity check; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module hex_escape_string_decoder_unit #(
  parameter int LENGTH_BITS = hesd_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  // source byte channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,

  // result word channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_is_final,
  output logic [1:0]                       out_status,
  output logic [hesd_pkg::LEN_OUT_W-1:0]   out_decoded_length,
  output logic                             out_last,

  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hesd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hesd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hesd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic [hesd_pkg::CAP_W-1:0] capacity;
  logic                       room;
  logic                       in_acc;
  hesd_pkg::push_t            push;
  hesd_pkg::result_t          head;

  // stall depends only on registered queue fill
  assign in_stall = ~room;
  assign in_acc   = in_valid & room;

  hesd_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // decode: escape phase, pending high digit, byte counter, error latch
  hesd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .in_byte  (in_byte),
    .capacity (capacity),
    .push     (push)
  );

  // result register stage, deep enough to absorb a two-word burst
  hesd_rqueue u_rqueue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte           = head.data;
  assign out_is_final       = head.is_final;
  assign out_status         = head.status;
  assign out_decoded_length = head.length;
  assign out_last           = head.last;

endmodule

// ----- design/hesd_checker.sv -----
// ----------------------------------------------------------------------------
// hesd_checker
// Port-level checks for the hex escape string decoder, bound to the top.
// ----------------------------------------------------------------------------
module hesd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_is_final,
  input logic [1:0]                     out_status,
  input logic [hesd_pkg::LEN_OUT_W-1:0] out_decoded_length,
  input logic                           out_last
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // the end-of-string word is always the last word of its input byte
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final |-> out_last)
    else $error("final word without last");

  // decoded byte words carry no status or length
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> (out_status == hesd_pkg::ST_OK) &&
                                   (out_decoded_length == '0))
    else $error("decoded byte word carries status or length");

  // reset leaves the queue empty and the input open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

endmodule

bind hex_escape_string_decoder_unit hesd_checker u_hesd_checker (.*);
